>>> sv/first_fit_heap_allocator_top_defines.svh
// assertion helpers for the allocator controller ffha_ctrl
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// checked only outside reset
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ffha_pkg.sv
package ffha_pkg;

	localparam int MAX_BLOCKS_DEF   = 256;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int PAD_BYTES_DEF    = 4;

	localparam logic [31:0] MEM_SIZE_RST   = 32'h0040_0000;
	localparam logic [31:0] HEAP_END_RST   = MEM_SIZE_RST - 32'(32 * 4096);
	localparam logic [31:0] HEAP_START_RST = 32'h0000_1000;

	localparam int SIZE_W = 23;

	typedef enum logic [1:0] {
		REG_HEAP_START  = 2'd0,
		REG_HEAP_END    = 2'd1,
		REG_MEMORY_SIZE = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_e;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_SIZE = 2'd1,
		ST_NO_MEMORY = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e;

	// one row of the block table
	typedef struct packed {
		logic [31:0]       start;
		logic [SIZE_W-1:0] size;
		logic              is_free;
	} entry_t;

	// configuration seen by the sequencer
	typedef struct packed {
		logic        clr;
		logic [31:0] start;
		logic [31:0] heap_end;
		logic [31:0] mem_size;
	} cfg_t;

endpackage

>>> sv/first_fit_heap_allocator_top.sv
// first-fit heap allocator
// input channel s_*: one command per transfer; s_tuser[0] is the kind
// (0 allocate, 1 free), s_tdata carries the request size and free address
// output channel m_*: exactly one result transfer per command, in order
// cfg_*: register writes, taken at any edge with cfg_we high; write only while
// idle, not enforced; a heap_start write empties the heap, resets the bump pointer
// walk: an item walks the block table one entry per cycle through the
// single read port of the table memory; a match goes from the walk to
// S_FIN, a walk that ends without one passes through S_MISS first (an
// empty table goes straight to S_MISS), and the zero-size and
// out-of-memory checks go straight from S_IDLE to S_FIN
// throughput: one command at a time; s_tready is high only when idle
// stall: the result waits in the output register while m_tready is low; a
// following command is taken meanwhile and holds before its result
// reset: arst_n clears the block count and used bytes, puts the bump
// pointer at the reset heap start and loads the register reset values;
// the table itself is not cleared, only entries below the count are read
module first_fit_heap_allocator_top #(
	parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int PAD_BYTES    = ffha_pkg::PAD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // alloc_size[22:0], free_address[54:23], zero fill
	input  logic [0:0]  s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // payload_address[31:0], used_bytes[63:32]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import ffha_pkg::*;

	logic [31:0] heap_end_q;
	logic [31:0] mem_size_q;
	cfg_t        cfg;
	kind_e       in_kind;
	logic [31:0] out_addr;
	status_e     out_status;
	logic [31:0] out_used;

	// configuration registers; heap_start lives only as the bump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_end_q <= HEAP_END_RST;
			mem_size_q <= MEM_SIZE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_e'(cfg_index))
				REG_HEAP_END:    heap_end_q <= cfg_data;
				REG_MEMORY_SIZE: mem_size_q <= cfg_data;
				REG_HEAP_START, REG_UNUSED: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.clr      = cfg_we && (reg_idx_e'(cfg_index) == REG_HEAP_START);
		cfg.start    = cfg_data;
		cfg.heap_end = heap_end_q;
		cfg.mem_size = mem_size_q;
		in_kind      = kind_e'(s_tuser[0]);
	end

	ffha_ctrl #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES),
		.PAD_BYTES    (PAD_BYTES)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.kind            (in_kind),
		.alloc_size      (s_tdata[22:0]),
		.free_address    (s_tdata[54:23]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.payload_address (out_addr),
		.status          (out_status),
		.used_bytes      (out_used)
	);

	assign m_tdata = {out_used, out_addr};
	assign m_tuser = out_status;

endmodule

>>> sv/ffha_table.sv
module ffha_table #(
	parameter int DEPTH = 256,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  ffha_pkg::entry_t    wdata,
	input  logic [IDX_W-1:0]    raddr,
	output ffha_pkg::entry_t    rdata
);
	import ffha_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/ffha_match.sv
module ffha_match #(
	parameter int HEADER_BYTES = 8
) (
	input  ffha_pkg::entry_t             entry,
	input  ffha_pkg::kind_e              kind,
	input  logic [ffha_pkg::SIZE_W-1:0]  req_size,
	input  logic [31:0]                  req_addr,
	output logic [31:0]                  payload,
	output logic                         hit
);
	import ffha_pkg::*;

	always_comb begin
		payload = entry.start + 32'(HEADER_BYTES);
		unique case (kind)
			KIND_ALLOC: hit = entry.is_free && (entry.size >= req_size);
			KIND_FREE:  hit = !entry.is_free && (payload == req_addr);
			default:    hit = 1'b0;
		endcase
	end

endmodule

>>> sv/ffha_ctrl.sv
`include "first_fit_heap_allocator_top_defines.svh"

module ffha_ctrl #(
	parameter int MAX_BLOCKS   = 256,
	parameter int HEADER_BYTES = 8,
	parameter int PAD_BYTES    = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffha_pkg::cfg_t               cfg,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  ffha_pkg::kind_e              kind,
	input  logic [ffha_pkg::SIZE_W-1:0]  alloc_size,
	input  logic [31:0]                  free_address,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  payload_address,
	output ffha_pkg::status_e            status,
	output logic [31:0]                  used_bytes
);
	import ffha_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [31:0] FP_ADD = 32'(HEADER_BYTES + PAD_BYTES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_FIN
	} state_t;

	state_t              state_q;
	kind_e               kind_q;
	logic [SIZE_W-1:0]   size_q;
	logic [31:0]         addr_q;
	logic [IDX_W-1:0]    scan_q;
	logic [CNT_W-1:0]    count_q;
	logic [31:0]         bump_q;
	logic [31:0]         used_q;
	logic [31:0]         res_addr_q;
	status_e             res_status_q;
	logic                out_valid_q;
	logic [31:0]         out_addr_q;
	status_e             out_status_q;
	logic [31:0]         out_used_q;

	logic                tbl_we;
	logic [IDX_W-1:0]    tbl_waddr;
	entry_t              tbl_wdata;
	logic [IDX_W-1:0]    tbl_raddr;
	entry_t              tbl_rdata;
	logic                hit;
	logic [31:0]         hit_payload;
	logic                last;
	logic                full;
	logic                heap_over;
	logic [33:0]         end_sum;
	logic [31:0]         fp_hit;
	logic [31:0]         fp_req;
	logic                append_ok;

	ffha_table #(
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	ffha_match #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_match (
		.entry    (tbl_rdata),
		.kind     (kind_q),
		.req_size (size_q),
		.req_addr (addr_q),
		.payload  (hit_payload),
		.hit      (hit)
	);

	always_comb begin
		// entry 0 is fetched while the item is taken, then one entry ahead
		tbl_raddr = (state_q == S_IDLE) ? '0 : scan_q + IDX_W'(1);
		last      = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
		full      = count_q == CNT_W'(MAX_BLOCKS);
		end_sum   = {2'b00, bump_q} + 34'(size_q) + 34'(HEADER_BYTES);
		heap_over = end_sum >= {2'b00, cfg.heap_end};
		fp_hit    = 32'(tbl_rdata.size) + FP_ADD;
		fp_req    = 32'(size_q) + FP_ADD;
		append_ok = (kind_q == KIND_ALLOC) && !full && !heap_over;
		tbl_we    = ((state_q == S_SCAN) && hit) || ((state_q == S_MISS) && append_ok);
		if (state_q == S_SCAN) begin
			tbl_waddr         = scan_q;
			tbl_wdata.start   = tbl_rdata.start;
			tbl_wdata.size    = tbl_rdata.size;
			tbl_wdata.is_free = (kind_q == KIND_FREE);
		end else begin
			tbl_waddr         = count_q[IDX_W-1:0];
			tbl_wdata.start   = bump_q;
			tbl_wdata.size    = size_q;
			tbl_wdata.is_free = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= KIND_ALLOC;
			size_q       <= '0;
			addr_q       <= '0;
			scan_q       <= '0;
			count_q      <= '0;
			bump_q       <= HEAP_START_RST;
			used_q       <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= ST_OK;
			out_used_q   <= '0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.clr) begin
				count_q <= '0;
				bump_q  <= cfg.start;
				used_q  <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q     <= kind;
						size_q     <= alloc_size;
						addr_q     <= free_address;
						scan_q     <= '0;
						res_addr_q <= '0;
						priority if (kind == KIND_ALLOC && alloc_size == '0) begin
							res_status_q <= ST_ZERO_SIZE;
							state_q      <= S_FIN;
						end else if (kind == KIND_ALLOC && bump_q >= cfg.mem_size) begin
							res_status_q <= ST_NO_MEMORY;
							state_q      <= S_FIN;
						end else if (count_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					priority if (hit) begin
						res_status_q <= ST_OK;
						if (kind_q == KIND_ALLOC) begin
							res_addr_q <= hit_payload;
							used_q     <= used_q + fp_hit;
						end else begin
							used_q <= used_q - fp_hit;
						end
						state_q <= S_FIN;
					end else if (last) begin
						state_q <= S_MISS;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				S_MISS: begin
					if (append_ok) begin
						res_addr_q   <= bump_q + 32'(HEADER_BYTES);
						res_status_q <= ST_OK;
						count_q      <= count_q + CNT_W'(1);
						bump_q       <= bump_q + fp_req;
						used_q       <= used_q + fp_req;
					end else if (kind_q == KIND_ALLOC) begin
						res_status_q <= ST_NO_MEMORY;
					end else begin
						res_status_q <= ST_NOT_FOUND;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// wait for the output register to be free
					if (!out_valid_q || m_tready) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						out_used_q   <= used_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready        = (state_q == S_IDLE);
	assign m_tvalid        = out_valid_q;
	assign payload_address = out_addr_q;
	assign status          = out_status_q;
	assign used_bytes      = out_used_q;

	`FFHA_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_BLOCKS), "block count overflow")
	`FFHA_ASSERT(a_one_item, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "second item taken")
	`FFHA_ASSERT(a_fail_zero, clk, arst_n, (m_tvalid && status != ST_OK) |-> payload_address == '0, "failed result with address")
	`FFHA_ASSERT_ALWAYS(a_no_idle_write, clk, tbl_we |-> state_q != S_IDLE, "table write while idle")

endmodule

>>> test/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;
	import ffha_pkg::*;

	localparam int          MAX_BLOCKS   = MAX_BLOCKS_DEF;
	localparam logic [31:0] HDR          = HEADER_BYTES_DEF;
	localparam logic [31:0] BLOCK_EXTRA  = HEADER_BYTES_DEF + PAD_BYTES_DEF;
	localparam int          LIMIT_CYCLES = 3_000_000;

	typedef struct {
		kind_e       kind;
		logic [22:0] size;
		logic [31:0] addr;
	} command_t;

	typedef struct {
		logic [31:0] addr;
		status_e     status;
		logic [31:0] used;
	} alloc_result_t;

	// dut ports, all known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	reg_idx_e    cfg_index = REG_HEAP_START;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata   = '0;   // alloc_size[22:0], free_address[54:23], zero fill
	logic [0:0]  s_tuser   = '0;   // kind[0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;          // payload_address[31:0], used_bytes[63:32]
	logic [1:0]  m_tuser;          // status[1:0]

	// stimulus and checking bookkeeping
	command_t      pending_cmds[$];
	alloc_result_t expected_results[$];
	logic          s_taken     = 1'b0;
	bit            idle_on     = 1'b1;
	int            s_gap       = 0;
	int            m_stall     = 0;
	int            cmds_queued = 0;
	int            results_seen = 0;
	int            mismatches  = 0;
	int            cycle_count = 0;

	// shadow of the allocator state
	logic [31:0] reg_heap_start, reg_heap_end, reg_mem_size;
	logic [31:0] tbl_start [MAX_BLOCKS];
	logic [22:0] tbl_size  [MAX_BLOCKS];
	bit          tbl_free  [MAX_BLOCKS];
	int          tbl_count;
	logic [31:0] bump_addr;
	logic [31:0] bytes_in_use;

	first_fit_heap_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// first-fit walk over the shadow table; updates the shadow state
	function automatic alloc_result_t predict_allocation(command_t c);
		alloc_result_t r;
		bit            found;
		logic [33:0]   reach;
		r.addr   = '0;
		r.status = ST_OK;
		found    = 1'b0;
		if (c.kind == KIND_ALLOC) begin
			if (c.size == '0) begin
				r.status = ST_ZERO_SIZE;
			end else if (bump_addr >= reg_mem_size) begin
				// checked before the walk, so a fitting free block does not help
				r.status = ST_NO_MEMORY;
			end else begin
				for (int i = 0; i < tbl_count && !found; i++) begin
					if (tbl_free[i] && tbl_size[i] >= c.size) begin
						// reused whole, never split
						tbl_free[i]  = 1'b0;
						bytes_in_use = bytes_in_use + {9'd0, tbl_size[i]} + BLOCK_EXTRA;
						r.addr       = tbl_start[i] + HDR;
						found        = 1'b1;
					end
				end
				if (!found) begin
					// heap bound is compared without wrap
					reach = {2'b0, bump_addr} + {11'd0, c.size} + {2'b0, HDR};
					if (tbl_count >= MAX_BLOCKS || reach >= {2'b0, reg_heap_end}) begin
						r.status = ST_NO_MEMORY;
					end else begin
						tbl_start[tbl_count] = bump_addr;
						tbl_size[tbl_count]  = c.size;
						tbl_free[tbl_count]  = 1'b0;
						tbl_count            = tbl_count + 1;
						r.addr               = bump_addr + HDR;
						// bump pointer wraps at 32 bits
						bump_addr            = bump_addr + {9'd0, c.size} + BLOCK_EXTRA;
						bytes_in_use         = bytes_in_use + {9'd0, c.size} + BLOCK_EXTRA;
					end
				end
			end
		end else begin
			r.status = ST_NOT_FOUND;
			for (int i = 0; i < tbl_count && !found; i++) begin
				if (tbl_start[i] + HDR == c.addr && !tbl_free[i]) begin
					tbl_free[i]  = 1'b1;
					bytes_in_use = bytes_in_use - ({9'd0, tbl_size[i]} + BLOCK_EXTRA);
					r.status     = ST_OK;
					found        = 1'b1;
				end
			end
		end
		r.used = bytes_in_use;
		return r;
	endfunction

	// mostly small sizes, some matched to blocks already in the table
	function automatic logic [22:0] pick_size(int big_pct);
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (r < big_pct)
			return 23'($urandom_range(1, 32'h40_0000));
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 55)
			return 23'($urandom_range(1, 64));
		if (r < 80 && tbl_count != 0) begin
			idx = $urandom_range(0, tbl_count - 1);
			return tbl_size[idx] + 23'($urandom_range(0, 2)) - 23'd1;
		end
		return 23'($urandom_range(1, 4096));
	endfunction

	// payload of a known block most of the time, otherwise near misses and noise
	function automatic logic [31:0] pick_free_address();
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (tbl_count != 0 && r < 90) begin
			idx = $urandom_range(0, tbl_count - 1);
			if (r < 80)
				return tbl_start[idx] + HDR;
			return tbl_start[idx] + HDR + 32'($urandom_range(1, 15));
		end
		return $urandom();
	endfunction

	task automatic queue_command(kind_e kind, logic [22:0] size, logic [31:0] addr);
		command_t c;
		c.kind = kind;
		c.size = size;
		c.addr = addr;
		// the field the command ignores still gets random bits
		if (kind == KIND_ALLOC)
			c.addr = $urandom();
		else
			c.size = 23'($urandom_range(0, 32'h40_0000));
		while (pending_cmds.size() >= 4)
			@(negedge clk);
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	task automatic run_random(int count, int alloc_pct, int big_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < alloc_pct)
				queue_command(KIND_ALLOC, pick_size(big_pct), '0);
			else
				queue_command(KIND_FREE, '0, pick_free_address());
		end
	endtask

	// every command answers once, so equal counts mean the block is idle
	task automatic wait_idle();
		while (results_seen != cmds_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(reg_idx_e idx, logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_HEAP_START: begin
				// a new heap start empties the heap
				reg_heap_start = value;
				tbl_count      = 0;
				bump_addr      = value;
				bytes_in_use   = '0;
			end
			REG_HEAP_END:    reg_heap_end = value;
			REG_MEMORY_SIZE: reg_mem_size = value;
			default: ;
		endcase
	endtask

	task automatic set_heap(logic [31:0] start, logic [31:0] stop, logic [31:0] mem);
		write_register(REG_HEAP_START, start);
		write_register(REG_HEAP_END, stop);
		write_register(REG_MEMORY_SIZE, mem);
	endtask

	// input side: predict at the transfer for the checker, flag it for the driver
	always @(posedge clk) begin
		s_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			command_t c;
			c.kind = kind_e'(s_tuser[0]);
			c.size = s_tdata[22:0];
			c.addr = s_tdata[54:23];
			expected_results.push_back(predict_allocation(c));
		end
	end

	// command driver: holds an item until its transfer, then idles or moves on
	always @(negedge clk) begin
		command_t c;
		if (arst_n && !(s_tvalid && !s_taken)) begin
			if (s_gap != 0) begin
				s_gap = s_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				c = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= c.kind;
				s_tdata  <= {1'b0, c.addr, c.size};
				if (idle_on && $urandom_range(0, 5) == 0)
					s_gap = $urandom_range(1, 10);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_stall != 0) begin
				m_stall = m_stall - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				m_stall = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, got addr %h status %0d used %h",
					$time, m_tdata[31:0], m_tuser, m_tdata[63:32]);
			end else begin
				e = expected_results.pop_front();
				if (m_tdata[31:0] !== e.addr || m_tuser !== e.status
						|| m_tdata[63:32] !== e.used) begin
					mismatches++;
					$display("%0t: mismatch, expected addr %h status %0d used %h, got addr %h status %0d used %h",
						$time, e.addr, e.status, e.used,
						m_tdata[31:0], m_tuser, m_tdata[63:32]);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] base;
		reg_heap_start = HEAP_START_RST;
		reg_heap_end   = HEAP_END_RST;
		reg_mem_size   = MEM_SIZE_RST;
		tbl_count      = 0;
		bump_addr      = HEAP_START_RST;
		bytes_in_use   = '0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset layout: zero size, heap overrun, reuse without split, double free
		queue_command(KIND_ALLOC, 23'd0, '0);
		queue_command(KIND_ALLOC, 23'h40_0000, '0);
		queue_command(KIND_ALLOC, 23'd16, '0);
		queue_command(KIND_ALLOC, 23'd32, '0);
		queue_command(KIND_FREE, '0, 32'h0000_1008);
		queue_command(KIND_FREE, '0, 32'h0000_1008);
		queue_command(KIND_FREE, '0, 32'h0000_0000);
		queue_command(KIND_FREE, '0, 32'hFFFF_FFFF);
		queue_command(KIND_ALLOC, 23'd8, '0);
		queue_command(KIND_ALLOC, 23'd16, '0);
		queue_command(KIND_FREE, '0, 32'h0000_1024);
		queue_command(KIND_ALLOC, 23'd33, '0);
		queue_command(KIND_ALLOC, 23'd32, '0);
		queue_command(KIND_ALLOC, 23'h3F_FFFF, '0);
		queue_command(KIND_FREE, '0, 32'h0000_1025);
		wait_idle();

		// one block that reaches one byte short of heap end, then reuse of it whole
		write_register(REG_HEAP_START, HEAP_START_RST);
		queue_command(KIND_ALLOC, 23'h3D_EFF7, '0);
		queue_command(KIND_FREE, '0, 32'h0000_1008);
		queue_command(KIND_ALLOC, 23'd1, '0);
		queue_command(KIND_ALLOC, 23'd1, '0);
		wait_idle();

		// bump pointer past memory size while a free block would fit
		set_heap(32'h0000_1000, HEAP_END_RST, 32'h0000_1100);
		queue_command(KIND_ALLOC, 23'd100, '0);
		queue_command(KIND_ALLOC, 23'd200, '0);
		queue_command(KIND_FREE, '0, 32'h0000_1008);
		queue_command(KIND_ALLOC, 23'd50, '0);
		queue_command(KIND_ALLOC, 23'd0, '0);
		queue_command(KIND_FREE, '0, 32'h0000_1078);
		wait_idle();

		// bump pointer wraps past the top of the address space
		set_heap(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_command(KIND_ALLOC, 23'hFF6, '0);
		queue_command(KIND_ALLOC, 23'h7FF, '0);
		queue_command(KIND_FREE, '0, 32'hFFFF_F008);
		run_random(10, 60, 0);
		wait_idle();

		// reset layout with small requests: the table fills up
		set_heap(HEAP_START_RST, HEAP_END_RST, MEM_SIZE_RST);
		write_register(REG_UNUSED, $urandom());
		run_random(600, 80, 0);
		wait_idle();

		// small memory size: allocations soon refused at the bump check
		base = $urandom_range(0, 32'h8000_0000);
		set_heap(base, 32'hFFFF_FFFF, base + 32'($urandom_range(500, 5000)));
		run_random(300, 65, 2);
		wait_idle();

		// degenerate bounds: no room at all, then no memory at all
		set_heap(32'h0, 32'h0, 32'hFFFF_FFFF);
		run_random(20, 70, 5);
		wait_idle();
		write_register(REG_MEMORY_SIZE, 32'h0);
		run_random(10, 70, 5);
		wait_idle();

		// random layouts
		for (int p = 0; p < 3; p++) begin
			base = $urandom_range(0, 32'hF000_0000);
			set_heap(base, base + 32'($urandom_range(0, 32'h10_0000)),
				($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
					: base + 32'($urandom_range(0, 32'h8_0000)));
			run_random(250, 60, 3);
			wait_idle();
		end

		// closing stretch at full rate on both sides
		set_heap(HEAP_START_RST, HEAP_END_RST, MEM_SIZE_RST);
		idle_on = 1'b0;
		run_random(250, 60, 2);
		wait_idle();
		repeat (MAX_BLOCKS + 8) @(negedge clk);

		if (expected_results.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
		end
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
